// File: rtl/sfs_pkg.sv
// shared types, codes and the result table of the spi nor flash sequencer
package sfs_pkg;

    // input operation codes
    localparam logic [2:0] OP_READ    = 3'd0;
    localparam logic [2:0] OP_PROGRAM = 3'd1;
    localparam logic [2:0] OP_ERASE   = 3'd2;
    localparam logic [2:0] OP_DATA    = 3'd3;
    localparam logic [2:0] OP_REPLY   = 3'd4;

    // request kinds as kept by the front end
    localparam logic [1:0] REQ_READ    = 2'd0;
    localparam logic [1:0] REQ_PROGRAM = 2'd1;
    localparam logic [1:0] REQ_ERASE   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_XFER = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // flash opcodes
    localparam logic [7:0] OPC_READ4 = 8'h13;
    localparam logic [7:0] OPC_PP4   = 8'h02;
    localparam logic [7:0] OPC_SE4   = 8'h20;
    localparam logic [7:0] OPC_WREN  = 8'h06;
    localparam logic [7:0] OPC_EN4B  = 8'hB7;
    localparam logic [7:0] OPC_EX4B  = 8'hE9;
    localparam logic [7:0] OPC_RDSR1 = 8'h05;
    localparam logic [7:0] OPC_RDSR3 = 8'h15;
    localparam logic [7:0] DUMMY     = 8'hFF;

    localparam logic [23:0] POLL_LIMIT_RESET = 24'd2000000;

    // flash geometry, both powers of two
    localparam int PAGE_BYTES   = 256;
    localparam int SECTOR_BYTES = 4096;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // transfer groups queued between front and back end
    typedef enum logic [3:0] {
        CMD_FINISH,
        CMD_READ_START,
        CMD_READ_MORE,
        CMD_READ_DONE,
        CMD_ENTER4,
        CMD_WEL,
        CMD_CLEANUP,
        CMD_POLL,
        CMD_PROGRAM,
        CMD_ERASE,
        CMD_DATA,
        CMD_DATA_POLL
    } cmd_t;

    typedef struct packed {
        cmd_t        code;
        logic [31:0] addr;
        logic [7:0]  data;
        logic        flag;
    } desc_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       frame_end;
        logic       want_reply;
        logic       success;
        logic       last;
    } res_t;

    // one result of a queued group at a given step
    function automatic res_t desc_result(desc_t d, logic [2:0] step);
        res_t       r;
        logic [7:0] ab;
        logic [7:0] first;
        logic [7:0] rdsr;
        r      = '0;
        r.kind = KIND_XFER;
        case (step)
            3'd1:    ab = d.addr[31:24];
            3'd2:    ab = d.addr[23:16];
            3'd3:    ab = d.addr[15:8];
            default: ab = d.addr[7:0];
        endcase
        case (d.code)
            CMD_ENTER4:  first = OPC_EN4B;
            CMD_WEL:     first = OPC_WREN;
            CMD_CLEANUP: first = OPC_EX4B;
            CMD_PROGRAM: first = OPC_PP4;
            CMD_ERASE:   first = OPC_SE4;
            default:     first = OPC_READ4;
        endcase
        rdsr = (d.code == CMD_WEL) ? OPC_RDSR1 : OPC_RDSR3;
        case (d.code)
            CMD_FINISH:
            begin
                r.kind    = KIND_DONE;
                r.success = d.flag;
                r.last    = 1'b1;
            end
            CMD_READ_START:
            begin
                if (step == 3'd0)
                begin
                    r.out_byte = OPC_READ4;
                end
                else if (step == 3'd5)
                begin
                    r.out_byte   = DUMMY;
                    r.frame_end  = d.flag;
                    r.want_reply = 1'b1;
                    r.last       = 1'b1;
                end
                else
                begin
                    r.out_byte = ab;
                end
            end
            CMD_READ_MORE, CMD_READ_DONE:
            begin
                if (step == 3'd0)
                begin
                    r.kind     = KIND_READ;
                    r.out_byte = d.data;
                end
                else if (d.code == CMD_READ_MORE)
                begin
                    r.out_byte   = DUMMY;
                    r.frame_end  = d.flag;
                    r.want_reply = 1'b1;
                    r.last       = 1'b1;
                end
                else
                begin
                    r.kind    = KIND_DONE;
                    r.success = 1'b1;
                    r.last    = 1'b1;
                end
            end
            CMD_ENTER4, CMD_WEL, CMD_CLEANUP:
            begin
                if (step == 3'd0)
                begin
                    r.out_byte  = first;
                    r.frame_end = 1'b1;
                end
                else if (step == 3'd1)
                begin
                    r.out_byte = rdsr;
                end
                else
                begin
                    r.out_byte   = DUMMY;
                    r.frame_end  = 1'b1;
                    r.want_reply = 1'b1;
                    r.last       = 1'b1;
                end
            end
            CMD_POLL:
            begin
                if (step == 3'd0)
                begin
                    r.out_byte = OPC_RDSR1;
                end
                else
                begin
                    r.out_byte   = DUMMY;
                    r.frame_end  = 1'b1;
                    r.want_reply = 1'b1;
                    r.last       = 1'b1;
                end
            end
            CMD_PROGRAM, CMD_ERASE:
            begin
                if (step == 3'd0)
                begin
                    r.out_byte = first;
                end
                else
                begin
                    r.out_byte = ab;
                    if (step == 3'd4)
                    begin
                        r.last       = 1'b1;
                        r.frame_end  = (d.code == CMD_ERASE);
                        r.want_reply = (d.code == CMD_ERASE);
                    end
                end
            end
            CMD_DATA:
            begin
                r.out_byte = d.data;
                r.last     = 1'b1;
            end
            CMD_DATA_POLL:
            begin
                if (step == 3'd0)
                begin
                    r.out_byte  = d.data;
                    r.frame_end = 1'b1;
                end
                else if (step == 3'd1)
                begin
                    r.out_byte = OPC_RDSR1;
                end
                else
                begin
                    r.out_byte   = DUMMY;
                    r.frame_end  = 1'b1;
                    r.want_reply = 1'b1;
                    r.last       = 1'b1;
                end
            end
            default:
            begin
                r.last = 1'b1;
            end
        endcase
        return r;
    endfunction

endpackage

// File: rtl/sfs_if.sv
// channel interfaces of the spi nor flash sequencer
interface sfs_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [31:0] address;
    logic [31:0] length;
    logic [7:0]  byte_value;
    modport source (output valid, op, address, length, byte_value, input ready);
    modport sink (input valid, op, address, length, byte_value, output ready);
endinterface

interface sfs_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       want_reply;
    logic       success;
    logic       last;
    modport source (output valid, kind, out_byte, frame_end, want_reply, success, last,
                    input ready);
    modport sink (input valid, kind, out_byte, frame_end, want_reply, success, last,
                  output ready);
endinterface

interface sfs_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] busy_poll_limit;
    modport source (output valid, busy_poll_limit, input ready);
    modport sink (input valid, busy_poll_limit, output ready);
endinterface

// File: rtl/sfs_front.sv
// front end: takes items, runs the command state machine, queues transfer groups
module sfs_front #(
    parameter longint unsigned CAPACITY_BYTES = 33554432
) (
    input  logic           clk,
    input  logic           rst_n,
    sfs_req_if.sink        req,
    sfs_cfg_if.sink        cfg,
    input  logic           q_ready,
    output logic           push,
    output sfs_pkg::desc_t push_desc
);
    import sfs_pkg::*;

    localparam int PW = $clog2(PAGE_BYTES);
    localparam int SW = $clog2(SECTOR_BYTES);
    localparam logic [PW:0] PAGE_D = (PW + 1)'(PAGE_BYTES);
    localparam logic [32:0] CAP    = 33'(CAPACITY_BYTES);
    localparam logic [32:0] SECT_W = 33'(SECTOR_BYTES);

    typedef enum logic [2:0] {
        PH_IDLE, PH_READ, PH_S3_ENTER, PH_WEL, PH_DATA, PH_ERASE_SENT, PH_POLL, PH_S3_EXIT
    } phase_t;

    phase_t         phase_reg, phase_next;
    logic [1:0]     kind_reg, kind_next;
    logic [31:0]    cur_addr_reg, cur_addr_next;
    logic [31:0]    bytes_left_reg, bytes_left_next;
    logic [PW:0]    page_left_reg, page_left_next;
    logic [23:0]    poll_count_reg, poll_count_next;
    logic           ok_reg, ok_next;
    logic [23:0]    limit_reg;

    logic           item_valid_reg;
    logic [2:0]     item_op_reg;
    logic [31:0]    item_addr_reg;
    logic [31:0]    item_len_reg;
    logic [7:0]     item_byte_reg;

    logic           consume;
    logic           push_c;
    desc_t          desc_c;
    logic           range_len_ok;
    logic           range_sect_ok;
    logic           sect_aligned;
    logic [PW:0]    room;

    assign consume = item_valid_reg && q_ready;

    assign req.ready = !item_valid_reg || consume;
    assign cfg.ready = 1'b1;
    assign push      = consume && push_c;
    assign push_desc = desc_c;

    // range checks against the flash size, offsets from the low address bits
    assign range_len_ok  = (item_len_reg != 32'd0) && ({1'b0, item_addr_reg} < CAP) &&
                           ({1'b0, item_len_reg} <= CAP - {1'b0, item_addr_reg});
    assign range_sect_ok = ({1'b0, item_addr_reg} < CAP) &&
                           (SECT_W <= CAP - {1'b0, item_addr_reg});
    assign sect_aligned  = (item_addr_reg[SW-1:0] == '0);
    assign room = PAGE_D - {1'b0, cur_addr_reg[PW-1:0]};

    // item decode and next state
    always_comb
    begin
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        cur_addr_next   = cur_addr_reg;
        bytes_left_next = bytes_left_reg;
        page_left_next  = page_left_reg;
        poll_count_next = poll_count_reg;
        ok_next         = ok_reg;
        push_c          = 1'b0;
        desc_c          = '0;
        desc_c.code     = CMD_FINISH;
        desc_c.data     = item_byte_reg;
        if (item_op_reg <= OP_ERASE)
        begin
            if (phase_reg == PH_IDLE)
            begin
                kind_next     = item_op_reg[1:0];
                cur_addr_next = item_addr_reg;
                push_c        = 1'b1;
                if (item_op_reg == OP_READ)
                begin
                    if (range_len_ok)
                    begin
                        bytes_left_next = item_len_reg;
                        desc_c.code     = CMD_READ_START;
                        desc_c.addr     = item_addr_reg;
                        desc_c.flag     = (item_len_reg == 32'd1);
                        phase_next      = PH_READ;
                    end
                end
                else if (item_op_reg == OP_PROGRAM)
                begin
                    if (range_len_ok)
                    begin
                        bytes_left_next = item_len_reg;
                        ok_next         = 1'b0;
                        desc_c.code     = CMD_ENTER4;
                        phase_next      = PH_S3_ENTER;
                    end
                end
                else
                begin
                    if (sect_aligned && range_sect_ok)
                    begin
                        bytes_left_next = 32'd0;
                        ok_next         = 1'b0;
                        desc_c.code     = CMD_ENTER4;
                        phase_next      = PH_S3_ENTER;
                    end
                end
            end
        end
        else if (item_op_reg == OP_DATA)
        begin
            if (phase_reg == PH_DATA)
            begin
                push_c          = 1'b1;
                page_left_next  = page_left_reg - 1'b1;
                bytes_left_next = bytes_left_reg - 32'd1;
                cur_addr_next   = cur_addr_reg + 32'd1;
                if (page_left_reg == (PW + 1)'(1))
                begin
                    desc_c.code     = CMD_DATA_POLL;
                    poll_count_next = 24'd1;
                    phase_next      = PH_POLL;
                end
                else
                begin
                    desc_c.code = CMD_DATA;
                end
            end
        end
        else if (item_op_reg == OP_REPLY)
        begin
            case (phase_reg)
                PH_READ:
                begin
                    push_c          = 1'b1;
                    bytes_left_next = bytes_left_reg - 32'd1;
                    if (bytes_left_reg != 32'd1)
                    begin
                        desc_c.code = CMD_READ_MORE;
                        desc_c.flag = (bytes_left_reg == 32'd2);
                    end
                    else
                    begin
                        desc_c.code = CMD_READ_DONE;
                        phase_next  = PH_IDLE;
                    end
                end
                PH_S3_ENTER:
                begin
                    push_c = 1'b1;
                    if (!item_byte_reg[0])
                    begin
                        desc_c.code = CMD_CLEANUP;
                        phase_next  = PH_S3_EXIT;
                    end
                    else
                    begin
                        desc_c.code = CMD_WEL;
                        phase_next  = PH_WEL;
                    end
                end
                PH_WEL:
                begin
                    push_c      = 1'b1;
                    desc_c.addr = cur_addr_reg;
                    if (!item_byte_reg[1])
                    begin
                        desc_c.code = CMD_CLEANUP;
                        phase_next  = PH_S3_EXIT;
                    end
                    else if (kind_reg == REQ_PROGRAM)
                    begin
                        page_left_next = (bytes_left_reg < 32'(room)) ?
                                         bytes_left_reg[PW:0] : room;
                        desc_c.code    = CMD_PROGRAM;
                        phase_next     = PH_DATA;
                    end
                    else
                    begin
                        desc_c.code = CMD_ERASE;
                        phase_next  = PH_ERASE_SENT;
                    end
                end
                PH_ERASE_SENT:
                begin
                    push_c          = 1'b1;
                    poll_count_next = 24'd1;
                    desc_c.code     = CMD_POLL;
                    phase_next      = PH_POLL;
                end
                PH_POLL:
                begin
                    push_c = 1'b1;
                    if (!item_byte_reg[0])
                    begin
                        if ((kind_reg == REQ_PROGRAM) && (bytes_left_reg != 32'd0))
                        begin
                            desc_c.code = CMD_WEL;
                            phase_next  = PH_WEL;
                        end
                        else
                        begin
                            ok_next     = 1'b1;
                            desc_c.code = CMD_CLEANUP;
                            phase_next  = PH_S3_EXIT;
                        end
                    end
                    else if (poll_count_reg >= limit_reg)
                    begin
                        ok_next     = 1'b0;
                        desc_c.code = CMD_CLEANUP;
                        phase_next  = PH_S3_EXIT;
                    end
                    else
                    begin
                        poll_count_next = poll_count_reg + 24'd1;
                        desc_c.code     = CMD_POLL;
                    end
                end
                PH_S3_EXIT:
                begin
                    push_c      = 1'b1;
                    ok_next     = ok_reg && !item_byte_reg[0];
                    desc_c.code = CMD_FINISH;
                    desc_c.flag = ok_reg && !item_byte_reg[0];
                    phase_next  = PH_IDLE;
                end
                default:
                begin
                    push_c = 1'b0;
                end
            endcase
        end
    end

    // state and item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            kind_reg       <= '0;
            cur_addr_reg   <= '0;
            bytes_left_reg <= '0;
            page_left_reg  <= '0;
            poll_count_reg <= '0;
            ok_reg         <= 1'b0;
            limit_reg      <= POLL_LIMIT_RESET;
            item_valid_reg <= 1'b0;
            item_op_reg    <= '0;
            item_addr_reg  <= '0;
            item_len_reg   <= '0;
            item_byte_reg  <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                limit_reg <= cfg.busy_poll_limit;
            end
            if (consume)
            begin
                phase_reg      <= phase_next;
                kind_reg       <= kind_next;
                cur_addr_reg   <= cur_addr_next;
                bytes_left_reg <= bytes_left_next;
                page_left_reg  <= page_left_next;
                poll_count_reg <= poll_count_next;
                ok_reg         <= ok_next;
            end
            if (req.valid && req.ready)
            begin
                item_valid_reg <= 1'b1;
                item_op_reg    <= req.op;
                item_addr_reg  <= req.address;
                item_len_reg   <= req.length;
                item_byte_reg  <= req.byte_value;
            end
            else if (consume)
            begin
                item_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/sfs_queue.sv
// short queue of transfer groups between front and back end
module sfs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sfs_pkg::desc_t push_desc,
    output logic           q_ready,
    input  logic           pop,
    output logic           q_valid,
    output sfs_pkg::desc_t head
);
    import sfs_pkg::*;

    desc_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign q_ready = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/sfs_back.sv
// back end: expands each queued group into results, one per cycle while the receiver is ready
module sfs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  sfs_pkg::desc_t head,
    output logic           pop,
    sfs_rsp_if.source      rsp
);
    import sfs_pkg::*;

    logic [2:0] step_reg;
    res_t       out_reg;
    logic       out_valid_reg;
    res_t       cur;
    logic       load;

    assign cur  = desc_result(head, step_reg);
    assign load = q_valid && (!out_valid_reg || rsp.ready);
    assign pop  = load && cur.last;

    assign rsp.valid      = out_valid_reg;
    assign rsp.kind       = out_reg.kind;
    assign rsp.out_byte   = out_reg.out_byte;
    assign rsp.frame_end  = out_reg.frame_end;
    assign rsp.want_reply = out_reg.want_reply;
    assign rsp.success    = out_reg.success;
    assign rsp.last       = out_reg.last;

    // output register and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_reg       <= cur;
                out_valid_reg <= 1'b1;
                step_reg      <= cur.last ? 3'd0 : step_reg + 3'd1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/spi_nor_flash_sequencer.sv
// top level of the spi nor flash command sequencer
//
//  channel  dir  carries
//  req      in   op, address, length, byte_value
//  rsp      out  kind, out_byte, frame_end, want_reply, success, last
//  cfg      in   busy_poll_limit
//
// one item is taken per cycle while the queue has room and is decoded in the cycle
// after its transfer; its results pass through the group queue and the output
// register, one result per cycle while the receiver is ready.
// reset clears all control state; the poll limit resets to 2000000.
// a four-entry queue lets the front end run on while the output is stalled; the input
// stalls only once the queue is full.
module spi_nor_flash_sequencer #(
    parameter longint unsigned CAPACITY_BYTES = 33554432
) (
    input  logic      clk,
    input  logic      rst_n,
    sfs_req_if.sink   req,
    sfs_rsp_if.source rsp,
    sfs_cfg_if.sink   cfg
);
    import sfs_pkg::*;

    logic  push;
    desc_t push_desc;
    logic  q_ready;
    logic  pop;
    logic  q_valid;
    desc_t head;

    // command decode
    sfs_front #(
        .CAPACITY_BYTES (CAPACITY_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg),
        .q_ready   (q_ready),
        .push      (push),
        .push_desc (push_desc)
    );

    // group queue
    sfs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .head      (head)
    );

    // result expansion
    sfs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .head    (head),
        .pop     (pop),
        .rsp     (rsp)
    );

endmodule

// File: rtl/sfs_checker.sv
// port checker for the spi nor flash sequencer and its bind
module sfs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] rsp_kind,
    input logic [7:0] rsp_out_byte,
    input logic       rsp_frame_end,
    input logic       rsp_want_reply,
    input logic       rsp_success,
    input logic       rsp_last
);
    import sfs_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
        $stable(rsp_out_byte) && $stable(rsp_last))
        else $error("stalled result changed");

    // only transfers carry frame and reply marks
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind != KIND_XFER) |-> !rsp_frame_end && !rsp_want_reply)
        else $error("marks on a non-transfer result");

    // success only on a completion
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind != KIND_DONE) |-> !rsp_success)
        else $error("success outside a completion");

    // a completion ends its item and carries no byte
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_DONE) |-> rsp_last && (rsp_out_byte == 8'd0))
        else $error("completion not last or with a byte");

    // a reply-wanted transfer ends its item
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_want_reply |-> rsp_last)
        else $error("reply-wanted transfer not last");

endmodule

bind spi_nor_flash_sequencer sfs_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_kind       (rsp.kind),
    .rsp_out_byte   (rsp.out_byte),
    .rsp_frame_end  (rsp.frame_end),
    .rsp_want_reply (rsp.want_reply),
    .rsp_success    (rsp.success),
    .rsp_last       (rsp.last)
);

// File: tb/tb_spi_nor_flash_sequencer.sv
// testbench for the spi nor flash sequencer: acts as host and flash, predicts every result
`timescale 1ns / 100ps

import sfs_pkg::*;

// sequencer step as tracked by the flash predictor
typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_S3_ENTER,
    ST_WEL,
    ST_DATA,
    ST_ERASE_SENT,
    ST_POLL,
    ST_S3_EXIT
} flash_step_t;

class flash_scoreboard;
    localparam longint unsigned CAP    = 33554432;
    localparam int unsigned     PAGE   = 256;
    localparam int unsigned     SECTOR = 4096;

    logic [23:0] poll_limit;
    flash_step_t step;
    logic [1:0]  req_kind;
    logic [31:0] cur_addr;
    logic [31:0] bytes_left;
    logic [31:0] page_left;
    logic [23:0] poll_count;
    logic        ok_flag;
    res_t        expected_results[$];
    res_t        batch[$];
    int          errors;

    function new();
        poll_limit = POLL_LIMIT_RESET;
        step       = ST_IDLE;
        req_kind   = REQ_READ;
        cur_addr   = '0;
        bytes_left = '0;
        page_left  = '0;
        poll_count = '0;
        ok_flag    = 1'b0;
        errors     = 0;
    endfunction

    function void put(logic [1:0] k, logic [7:0] b, logic fe, logic wr, logic ok);
        res_t r;
        r = '0;
        r.kind       = k;
        r.out_byte   = b;
        r.frame_end  = fe;
        r.want_reply = wr;
        r.success    = ok;
        batch.push_back(r);
    endfunction

    function void spi(logic [7:0] b, logic fe, logic wr);
        put(KIND_XFER, b, fe, wr, 1'b0);
    endfunction

    function void addr_bytes(logic [31:0] a, logic fe, logic wr);
        spi(a[31:24], 1'b0, 1'b0);
        spi(a[23:16], 1'b0, 1'b0);
        spi(a[15:8], 1'b0, 1'b0);
        spi(a[7:0], fe, wr);
    endfunction

    function bit in_range(logic [31:0] a, logic [31:0] len);
        return len != 0 && longint'(a) < CAP && longint'(len) <= CAP - longint'(a);
    endfunction

    function void done(logic ok);
        put(KIND_DONE, 8'h00, 1'b0, 1'b0, ok);
        step = ST_IDLE;
    endfunction

    function void wel_check();
        spi(OPC_WREN, 1'b1, 1'b0);
        spi(OPC_RDSR1, 1'b0, 1'b0);
        spi(DUMMY, 1'b1, 1'b1);
        step = ST_WEL;
    endfunction

    function void busy_poll();
        spi(OPC_RDSR1, 1'b0, 1'b0);
        spi(DUMMY, 1'b1, 1'b1);
        step = ST_POLL;
    endfunction

    function void leave_4byte();
        spi(OPC_EX4B, 1'b1, 1'b0);
        spi(OPC_RDSR3, 1'b0, 1'b0);
        spi(DUMMY, 1'b1, 1'b1);
        step = ST_S3_EXIT;
    endfunction

    function void enter_4byte();
        spi(OPC_EN4B, 1'b1, 1'b0);
        spi(OPC_RDSR3, 1'b0, 1'b0);
        spi(DUMMY, 1'b1, 1'b1);
        ok_flag = 1'b0;
        step    = ST_S3_ENTER;
    endfunction

    // true when the item would be dropped without any result
    function bit ignored(logic [2:0] op);
        if (op > OP_REPLY)
            return 1;
        if (op <= OP_ERASE)
            return step != ST_IDLE;
        if (op == OP_DATA)
            return step != ST_DATA;
        return step == ST_IDLE || step == ST_DATA;
    endfunction

    // accepted input: work out its results, returns how many
    function int note_input(logic [2:0] op, logic [31:0] a, logic [31:0] len, logic [7:0] b);
        logic [31:0] room;
        batch.delete();
        if (op <= OP_ERASE)
        begin
            if (step == ST_IDLE)
            begin
                req_kind = op[1:0];
                cur_addr = a;
                if (op == OP_READ)
                begin
                    if (!in_range(a, len))
                        done(1'b0);
                    else
                    begin
                        bytes_left = len;
                        spi(OPC_READ4, 1'b0, 1'b0);
                        addr_bytes(a, 1'b0, 1'b0);
                        spi(DUMMY, len == 1, 1'b1);
                        step = ST_READ;
                    end
                end
                else if (op == OP_PROGRAM)
                begin
                    if (!in_range(a, len))
                        done(1'b0);
                    else
                    begin
                        bytes_left = len;
                        enter_4byte();
                    end
                end
                else
                begin
                    if (a % SECTOR != 0 || !in_range(a, SECTOR))
                        done(1'b0);
                    else
                    begin
                        bytes_left = '0;
                        enter_4byte();
                    end
                end
            end
        end
        else if (op == OP_DATA)
        begin
            if (step == ST_DATA)
            begin
                spi(b, page_left == 1, 1'b0);
                page_left--;
                bytes_left--;
                cur_addr++;
                if (page_left == 0)
                begin
                    poll_count = 24'd1;
                    busy_poll();
                end
            end
        end
        else if (op == OP_REPLY)
        begin
            case (step)
                ST_READ:
                begin
                    put(KIND_READ, b, 1'b0, 1'b0, 1'b0);
                    bytes_left--;
                    if (bytes_left > 0)
                        spi(DUMMY, bytes_left == 1, 1'b1);
                    else
                        done(1'b1);
                end
                ST_S3_ENTER:
                begin
                    if (!b[0])
                        leave_4byte();
                    else
                        wel_check();
                end
                ST_WEL:
                begin
                    if (!b[1])
                        leave_4byte();
                    else if (req_kind == REQ_PROGRAM)
                    begin
                        room      = PAGE - (cur_addr % PAGE);
                        page_left = (bytes_left < room) ? bytes_left : room;
                        spi(OPC_PP4, 1'b0, 1'b0);
                        addr_bytes(cur_addr, 1'b0, 1'b0);
                        step = ST_DATA;
                    end
                    else
                    begin
                        spi(OPC_SE4, 1'b0, 1'b0);
                        addr_bytes(cur_addr, 1'b1, 1'b1);
                        step = ST_ERASE_SENT;
                    end
                end
                ST_ERASE_SENT:
                begin
                    poll_count = 24'd1;
                    busy_poll();
                end
                ST_POLL:
                begin
                    if (!b[0])
                    begin
                        if (req_kind == REQ_PROGRAM && bytes_left > 0)
                            wel_check();
                        else
                        begin
                            ok_flag = 1'b1;
                            leave_4byte();
                        end
                    end
                    else if (poll_count >= poll_limit)
                    begin
                        ok_flag = 1'b0;
                        leave_4byte();
                    end
                    else
                    begin
                        poll_count++;
                        busy_poll();
                    end
                end
                ST_S3_EXIT:
                begin
                    if (b[0])
                        ok_flag = 1'b0;
                    done(ok_flag);
                end
                default:
                begin
                end
            endcase
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_results.push_back(batch[i]);
        return batch.size();
    endfunction

    task report(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    // accepted result against the oldest expectation
    task check_result(res_t got);
        res_t exp;
        if (expected_results.size() == 0)
        begin
            report($sformatf("unexpected result %p", got));
            return;
        end
        exp = expected_results.pop_front();
        if (got.kind !== exp.kind)
            report($sformatf("kind %0d, expected %0d", got.kind, exp.kind));
        if (got.out_byte !== exp.out_byte)
            report($sformatf("out_byte %h, expected %h", got.out_byte, exp.out_byte));
        if (got.frame_end !== exp.frame_end)
            report($sformatf("frame_end %b, expected %b", got.frame_end, exp.frame_end));
        if (got.want_reply !== exp.want_reply)
            report($sformatf("want_reply %b, expected %b", got.want_reply, exp.want_reply));
        if (got.success !== exp.success)
            report($sformatf("success %b, expected %b", got.success, exp.success));
        if (got.last !== exp.last)
            report($sformatf("last %b, expected %b", got.last, exp.last));
    endtask
endclass

module tb_spi_nor_flash_sequencer;
    localparam logic [31:0] CAP = 32'd33554432;

    logic clk;
    logic rst_n;
    logic quiet;
    int   item_count;

    flash_scoreboard sb;

    sfs_req_if req_ch();
    sfs_rsp_if rsp_ch();
    sfs_cfg_if cfg_ch();

    spi_nor_flash_sequencer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side: random stalls of the receiver
    initial
    begin
        rsp_ch.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
        end
    end

    // result transfer check
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            res_t got;
            got.kind       = rsp_ch.kind;
            got.out_byte   = rsp_ch.out_byte;
            got.frame_end  = rsp_ch.frame_end;
            got.want_reply = rsp_ch.want_reply;
            got.success    = rsp_ch.success;
            got.last       = rsp_ch.last;
            sb.check_result(got);
        end
    end

    // one request transfer, optionally after an idle burst
    task drive_item(logic [2:0] op, logic [31:0] a, logic [31:0] len, logic [7:0] b);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.op         = op;
        req_ch.address    = a;
        req_ch.length     = len;
        req_ch.byte_value = b;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (sb.note_input(op, a, len, b) > 0)
            item_count++;
        @(negedge clk);
    endtask

    // an item the sequencer must drop in its present step
    task drive_noise();
        logic [2:0] op;
        do
            op = 3'($urandom_range(0, 7));
        while (!sb.ignored(op));
        drive_item(op, $urandom, $urandom, 8'($urandom));
    endtask

    // flash side answer for the step the sequencer is in
    function logic [7:0] flash_reply();
        logic [7:0] b;
        b = 8'($urandom);
        case (sb.step)
            ST_S3_ENTER: b[0] = ($urandom_range(0, 9) != 0);
            ST_WEL:      b[1] = ($urandom_range(0, 9) != 0);
            ST_POLL:     b[0] = ($urandom_range(0, 2) == 0);
            ST_S3_EXIT:  b[0] = ($urandom_range(0, 9) == 0);
            default:     b = b;
        endcase
        return b;
    endfunction

    // start a request and play the flash until the sequencer is idle again
    task run_request(logic [2:0] op, logic [31:0] a, logic [31:0] len);
        drive_item(op, a, len, 8'($urandom));
        while (sb.step != ST_IDLE)
        begin
            if ($urandom_range(0, 15) == 0)
                drive_noise();
            else if (sb.step == ST_DATA)
                drive_item(OP_DATA, $urandom, $urandom, 8'($urandom));
            else
                drive_item(OP_REPLY, $urandom, $urandom, flash_reply());
        end
    endtask

    task random_request();
        int unsigned k;
        logic [31:0] a;
        logic [31:0] len;
        k = $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0)
        begin
            run_request(k[2:0], $urandom, $urandom);
            return;
        end
        case (k)
            0:
            begin
                len = $urandom_range(1, 6);
                a   = $urandom_range(0, CAP - len);
                if ($urandom_range(0, 3) == 0)
                    a = CAP - len;
                run_request(OP_READ, a, len);
            end
            1:
            begin
                len = $urandom_range(1, 24);
                a   = $urandom_range(0, 131071) * 256 + $urandom_range(230, 255);
                run_request(OP_PROGRAM, a, len);
            end
            default:
            begin
                a = $urandom_range(0, CAP / 4096 - 1) * 4096;
                run_request(OP_ERASE, a, 32'd0);
            end
        endcase
    endtask

    task write_limit(logic [23:0] v);
        req_ch.valid       = 1'b0;
        cfg_ch.valid       = 1'b1;
        cfg_ch.busy_poll_limit = v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.poll_limit = v;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task wait_drained();
        req_ch.valid = 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        logic [23:0] limits[4];
        sb                     = new();
        quiet                  = 1'b0;
        item_count             = 0;
        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.op              = OP_READ;
        req_ch.address         = '0;
        req_ch.length          = '0;
        req_ch.byte_value      = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.busy_poll_limit = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // directed: range edges, page crossing, sector edges, bad requests
        run_request(OP_READ, 32'h0, 32'd1);
        run_request(OP_READ, CAP - 32'd1, 32'd1);
        run_request(OP_READ, CAP - 32'd3, 32'd3);
        run_request(OP_READ, CAP - 32'd1, 32'd2);
        run_request(OP_READ, 32'h0, 32'h0);
        run_request(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_request(OP_PROGRAM, 32'h0000_00FE, 32'd4);
        run_request(OP_PROGRAM, CAP - 32'd2, 32'd2);
        run_request(OP_PROGRAM, CAP, 32'd1);
        run_request(OP_ERASE, 32'h0000_1000, 32'h0);
        run_request(OP_ERASE, CAP - 32'd4096, 32'h0);
        run_request(OP_ERASE, 32'h0000_1001, 32'h0);
        run_request(OP_ERASE, CAP, 32'h0);
        drive_item(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        drive_item(OP_REPLY, 32'h0, 32'h0, 8'h00);
        wait_drained();

        // random phases over several poll limits, last one without idling
        limits[0] = 24'd1;
        limits[1] = 24'hFF_FFFF;
        limits[2] = 24'd2;
        limits[3] = 24'($urandom_range(1, 5));
        foreach (limits[i])
        begin
            write_limit(limits[i]);
            if (i == 3)
                quiet = 1'b1;
            while (item_count < 60 * (i + 1) + 20)
                random_request();
            wait_drained();
        end

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
